@@ rtl/lzd_pkg.sv @@
package lzd_pkg;

	localparam int OUTPUT_LIMIT = 32768;
	localparam int WINDOW_DEPTH = 8192;
	localparam int CHUNK_BYTES  = 8;
	localparam int HIST_AW      = $clog2(WINDOW_DEPTH);

	// end codes carried on the status field
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_MODE  = 2'd1;
	localparam logic [1:0] ST_BAD_DIST  = 2'd2;
	localparam logic [1:0] ST_LIMIT     = 2'd3;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  count;
		logic        fin;
		logic [1:0]  st;
	} res_t;

endpackage

@@ rtl/lzd_hist_ram.sv @@
module lzd_hist_ram #(
	parameter int AW = 13,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [0:(1<<AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/two_mode_lz_decompressor.sv @@
// channel | signals                                              | direction
// input   | in_valid, in_stall, in_byte                          | in, stall out
// output  | out_valid, out_stall, out_data, out_count,           | out, stall in
//         | last_of_run, stream_end, status                      |
// one compressed byte is taken at a time; in_stall stays high until every result
// of that byte has reached the output register.
// a copy is bounded by one history read a cycle while the output does not stall.
// reset clears all control state; history contents are left as they are.
// a stall on the output holds the parser and the copy walk where they stand.
module two_mode_lz_decompressor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] out_data,
	output logic [3:0]  out_count,
	output logic        last_of_run,
	output logic        stream_end,
	output logic [1:0]  status
);
	import lzd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_M0, S_M1, S_COPY, S_CFLUSH, S_ENDF, S_END, S_LAST
	} state_t;
	typedef enum logic [1:0] {MD_WAIT, MD_ZERO, MD_ONE} mode_t;
	typedef enum logic [1:0] {PH_START, PH_MID, PH_LAST} phase_t;

	state_t      state_q;
	mode_t       mode_q;
	phase_t      phase_q;
	logic        finished_q;
	logic [15:0] produced_q;
	logic [23:0] buf_q;
	logic [4:0]  fill_q;
	logic [7:0]  flag_q;
	logic [3:0]  left_q;
	logic [7:0]  plo_q;
	logic [7:0]  phi_q;
	logic [7:0]  byte_q;
	logic [15:0] src_q;
	logic [8:0]  rem_q;
	logic        ret_m0_q;
	logic [1:0]  end_st_q;
	logic [63:0] chunk_q;
	logic [3:0]  chunk_n_q;
	logic        cp_v_s1;
	logic        fwd_s1;
	logic [7:0]  fwd_data_s1;
	res_t        pend_q;
	logic        pend_v_q;
	res_t        out_q;
	logic        out_v_q;
	logic        out_last_q;

	logic        out_free, can_push, push, move, lit_ok, lim, step, issue;
	res_t        push_res;
	logic [7:0]  cp_byte, ram_rdata;
	logic [63:0] chunk_nx;
	logic        hist_we;
	logic [7:0]  hist_wdata;
	logic        m1_lit;

	// mode 0 decode
	logic        m0_need, m0_lit, m0_end, m0_copy, m0_go;
	logic [1:0]  m0_end_st;
	logic [4:0]  m0_drop;
	phase_t      m0_phase_nx;
	logic [7:0]  m0_plo_nx;
	logic [15:0] m0_dist;
	logic [15:0] span;
	logic [3:0]  nb;
	logic [12:0] mask;

	// mode 1 distance forms
	logic [15:0] m1_d_pair, m1_d_ext;

	assign out_free = !out_v_q || !out_stall;
	assign can_push = !pend_v_q || out_free;
	assign lit_ok   = produced_q < 16'(OUTPUT_LIMIT);
	assign lim      = !lit_ok;
	assign step     = (state_q == S_COPY) && cp_v_s1 && can_push && !lim;
	assign issue    = (state_q == S_COPY) && !(cp_v_s1 && lim) && (!cp_v_s1 || step)
		&& (rem_q != 9'd0);
	assign cp_byte  = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign chunk_nx = chunk_q | ({56'd0, cp_byte} << {chunk_n_q[2:0], 3'b000});
	assign m1_lit   = (phase_q == PH_START) && (left_q != 4'd0) && !flag_q[7];
	assign m1_d_pair = {4'd0, plo_q[7:4], byte_q};
	assign m1_d_ext  = {4'd0, plo_q[7:4], phi_q};

	// far distance width follows how much has been produced
	always_comb begin
		span = produced_q - 16'd33;
		nb   = 4'd0;
		if (span[15:11] != 5'd0) begin
			nb = 4'd12;
		end else begin
			for (int i = 0; i < 11; i++) begin
				if (span[i]) nb = 4'(i + 1);
			end
		end
		mask = (13'd1 << nb) - 13'd1;
	end

	always_comb begin
		m0_need = 1'b0; m0_lit = 1'b0; m0_end = 1'b0; m0_copy = 1'b0; m0_go = 1'b0;
		m0_end_st = ST_OK; m0_drop = 5'd0; m0_phase_nx = phase_q; m0_plo_nx = plo_q;
		m0_dist = 16'd0;
		case (phase_q)
			PH_START: begin
				if (fill_q < 5'd1) m0_need = 1'b1;
				else if (buf_q[0]) begin
					if (fill_q < 5'd9) m0_need = 1'b1;
					else begin m0_lit = 1'b1; m0_drop = 5'd9; end
				end
				else if (fill_q < 5'd2) m0_need = 1'b1;
				else if (!buf_q[1]) begin
					m0_plo_nx = 8'd2; m0_drop = 5'd2; m0_phase_nx = PH_LAST;
				end
				else if (fill_q < 5'd3) m0_need = 1'b1;
				else if (!buf_q[2]) begin
					m0_plo_nx = 8'd3; m0_drop = 5'd3; m0_phase_nx = PH_LAST;
				end
				else if (fill_q < 5'd4) m0_need = 1'b1;
				else if (!buf_q[3]) begin
					m0_plo_nx = 8'd4; m0_drop = 5'd4; m0_phase_nx = PH_LAST;
				end
				else if (fill_q < 5'd5) m0_need = 1'b1;
				else if (!buf_q[4]) begin
					m0_plo_nx = 8'd5; m0_drop = 5'd5; m0_phase_nx = PH_LAST;
				end
				else if (fill_q < 5'd6) m0_need = 1'b1;
				else if (buf_q[5]) begin
					m0_drop = 5'd6; m0_phase_nx = PH_MID;
				end
				else if (fill_q < 5'd7) m0_need = 1'b1;
				else begin
					m0_plo_nx = buf_q[6] ? 8'd7 : 8'd6; m0_drop = 5'd7;
					m0_phase_nx = PH_LAST;
				end
			end
			PH_MID: begin
				if (fill_q < 5'd2) m0_need = 1'b1;
				else if (buf_q[1:0] != 2'd0) begin
					m0_drop = 5'd2; m0_plo_nx = {6'd0, buf_q[1:0]} + 8'd7;
					m0_phase_nx = PH_LAST;
				end
				else if (fill_q < 5'd9) m0_need = 1'b1;
				else if (buf_q[8:2] == 7'd0) begin
					m0_end = 1'b1; m0_end_st = ST_OK;
				end
				else begin
					m0_drop = 5'd9; m0_plo_nx = {1'b0, buf_q[8:2]} + 8'd10;
					m0_phase_nx = PH_LAST;
				end
			end
			PH_LAST: begin
				if (fill_q < 5'd1) m0_need = 1'b1;
				else if (buf_q[0]) begin
					if (fill_q < 5'd6) m0_need = 1'b1;
					else begin
						m0_go = 1'b1; m0_drop = 5'd6;
						m0_dist = 16'd1 + {11'd0, buf_q[5:1]};
					end
				end
				else if (produced_q <= 16'd33) begin
					m0_end = 1'b1; m0_end_st = ST_BAD_DIST;
				end
				else if (fill_q < (5'(nb) + 5'd1)) m0_need = 1'b1;
				else begin
					m0_go = 1'b1; m0_drop = 5'(nb) + 5'd1;
					m0_dist = 16'd33 + {4'd0, buf_q[12:1] & mask[11:0]};
				end
				if (m0_go) begin
					m0_phase_nx = PH_START;
					if (m0_dist > produced_q) begin
						m0_end = 1'b1; m0_end_st = ST_BAD_DIST;
					end else begin
						m0_copy = 1'b1;
					end
				end
			end
			default: m0_need = 1'b1;
		endcase
	end

	always_comb begin
		push = 1'b0;
		push_res = '0;
		case (state_q)
			S_M0: begin
				if (can_push && !m0_need && !m0_end && m0_lit && lit_ok) begin
					push = 1'b1;
					push_res.data = {56'd0, buf_q[8:1]};
					push_res.count = 4'd1;
				end
			end
			S_M1: begin
				if (can_push && m1_lit && lit_ok) begin
					push = 1'b1;
					push_res.data = {56'd0, byte_q};
					push_res.count = 4'd1;
				end
			end
			S_COPY: begin
				if (step && (chunk_n_q + 4'd1 == 4'(CHUNK_BYTES))) begin
					push = 1'b1;
					push_res.data = chunk_nx;
					push_res.count = chunk_n_q + 4'd1;
				end
			end
			S_CFLUSH, S_ENDF: begin
				if (can_push && chunk_n_q != 4'd0) begin
					push = 1'b1;
					push_res.data = chunk_q;
					push_res.count = chunk_n_q;
				end
			end
			S_END: begin
				if (can_push) begin
					push = 1'b1;
					push_res.fin = 1'b1;
					push_res.st = end_st_q;
				end
			end
			default: push = 1'b0;
		endcase
	end

	assign move = pend_v_q && out_free && (push || state_q == S_LAST);

	always_comb begin
		hist_we = 1'b0;
		hist_wdata = cp_byte;
		case (state_q)
			S_M0: begin
				hist_we = can_push && !m0_need && !m0_end && m0_lit && lit_ok;
				hist_wdata = buf_q[8:1];
			end
			S_M1: begin
				hist_we = can_push && m1_lit && lit_ok;
				hist_wdata = byte_q;
			end
			S_COPY: hist_we = step;
			default: hist_we = 1'b0;
		endcase
	end

	lzd_hist_ram #(.AW(HIST_AW), .DW(8)) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (produced_q[HIST_AW-1:0]),
		.wdata (hist_wdata),
		.re    (issue),
		.raddr (src_q[HIST_AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; mode_q <= MD_WAIT; phase_q <= PH_START;
			finished_q <= 1'b0; produced_q <= '0; buf_q <= '0; fill_q <= '0;
			flag_q <= '0; left_q <= '0; plo_q <= '0; phi_q <= '0; byte_q <= '0;
			src_q <= '0; rem_q <= '0; ret_m0_q <= 1'b0; end_st_q <= ST_OK;
			chunk_q <= '0; chunk_n_q <= '0; cp_v_s1 <= 1'b0; fwd_s1 <= 1'b0;
			fwd_data_s1 <= '0; pend_q <= '0; pend_v_q <= 1'b0; out_q <= '0;
			out_v_q <= 1'b0; out_last_q <= 1'b0;
		end else begin
			// result holding slot and output register
			if (push) begin
				pend_q <= push_res; pend_v_q <= 1'b1;
			end else if (move) begin
				pend_v_q <= 1'b0;
			end
			if (move) begin
				out_q <= pend_q; out_v_q <= 1'b1; out_last_q <= (state_q == S_LAST);
			end else if (out_free) begin
				out_v_q <= 1'b0;
			end
			if (hist_we) produced_q <= produced_q + 16'd1;
			if (issue) begin
				fwd_s1 <= hist_we && (produced_q[HIST_AW-1:0] == src_q[HIST_AW-1:0]);
				fwd_data_s1 <= hist_wdata;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid && !finished_q) begin
						case (mode_q)
							MD_WAIT: begin
								if (in_byte == 8'd0) mode_q <= MD_ZERO;
								else if (in_byte == 8'd1) mode_q <= MD_ONE;
								else begin
									end_st_q <= ST_BAD_MODE; state_q <= S_END;
								end
							end
							MD_ZERO: begin
								buf_q <= buf_q | ({16'd0, in_byte} << fill_q);
								fill_q <= fill_q + 5'd8;
								state_q <= S_M0;
							end
							default: begin
								byte_q <= in_byte; state_q <= S_M1;
							end
						endcase
					end
				end
				S_M0: begin
					if (can_push) begin
						if (m0_need) state_q <= S_LAST;
						else if (m0_end) begin
							end_st_q <= m0_end_st; state_q <= S_END;
						end else if (m0_lit && !lit_ok) begin
							end_st_q <= ST_LIMIT; state_q <= S_END;
						end else begin
							buf_q <= buf_q >> m0_drop;
							fill_q <= fill_q - m0_drop;
							phase_q <= m0_phase_nx;
							plo_q <= m0_plo_nx;
							if (m0_copy) begin
								src_q <= produced_q - m0_dist;
								rem_q <= {1'b0, plo_q};
								ret_m0_q <= 1'b1;
								state_q <= S_COPY;
							end
						end
					end
				end
				S_M1: begin
					if (can_push) begin
						state_q <= S_LAST;
						case (phase_q)
							PH_START: begin
								if (left_q == 4'd0) begin
									flag_q <= byte_q; left_q <= 4'd8;
								end else begin
									flag_q <= {flag_q[6:0], 1'b0};
									left_q <= left_q - 4'd1;
									if (!flag_q[7]) begin
										if (!lit_ok) begin
											end_st_q <= ST_LIMIT; state_q <= S_END;
										end
									end else begin
										plo_q <= byte_q; phase_q <= PH_MID;
									end
								end
							end
							PH_MID: begin
								phi_q <= byte_q;
								phase_q <= PH_START;
								if (plo_q == 8'd0 && byte_q == 8'd0) begin
									end_st_q <= ST_OK; state_q <= S_END;
								end else if (m1_d_pair > produced_q) begin
									end_st_q <= ST_BAD_DIST; state_q <= S_END;
								end else if (plo_q[3:0] == 4'd0) begin
									phase_q <= PH_LAST;
								end else if (m1_d_pair == 16'd0) begin
									end_st_q <= ST_BAD_DIST; state_q <= S_END;
								end else begin
									src_q <= produced_q - m1_d_pair;
									rem_q <= {5'd0, plo_q[3:0]} + 9'd1;
									ret_m0_q <= 1'b0;
									state_q <= S_COPY;
								end
							end
							default: begin
								phase_q <= PH_START;
								if (m1_d_ext == 16'd0 || m1_d_ext > produced_q) begin
									end_st_q <= ST_BAD_DIST; state_q <= S_END;
								end else begin
									src_q <= produced_q - m1_d_ext;
									rem_q <= {1'b0, byte_q} + 9'd17;
									ret_m0_q <= 1'b0;
									state_q <= S_COPY;
								end
							end
						endcase
					end
				end
				S_COPY: begin
					if (cp_v_s1 && lim) begin
						// byte would pass the output limit: drop the walk
						cp_v_s1 <= 1'b0;
						end_st_q <= ST_LIMIT;
						state_q <= S_ENDF;
					end else begin
						if (step) begin
							if (chunk_n_q + 4'd1 == 4'(CHUNK_BYTES)) begin
								chunk_q <= '0; chunk_n_q <= 4'd0;
							end else begin
								chunk_q <= chunk_nx; chunk_n_q <= chunk_n_q + 4'd1;
							end
						end
						if (issue) begin
							cp_v_s1 <= 1'b1;
							src_q <= src_q + 16'd1;
							rem_q <= rem_q - 9'd1;
						end else if (!cp_v_s1 || step) begin
							cp_v_s1 <= 1'b0;
							if (!cp_v_s1) state_q <= S_CFLUSH;
						end
					end
				end
				S_CFLUSH: begin
					if (can_push) begin
						chunk_q <= '0; chunk_n_q <= 4'd0;
						state_q <= ret_m0_q ? S_M0 : S_LAST;
					end
				end
				S_ENDF: begin
					if (can_push) begin
						chunk_q <= '0; chunk_n_q <= 4'd0;
						state_q <= S_END;
					end
				end
				S_END: begin
					if (can_push) begin
						finished_q <= 1'b1;
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					if (!pend_v_q || out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_v_q;
	assign out_data    = out_q.data;
	assign out_count   = out_q.count;
	assign last_of_run = out_last_q;
	assign stream_end  = out_q.fin;
	assign status      = out_q.st;

endmodule

@@ rtl/lzd_checker.sv @@
module lzd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  in_byte,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] out_data,
	input logic [3:0]  out_count,
	input logic        last_of_run,
	input logic        stream_end,
	input logic [1:0]  status
);
	import lzd_pkg::*;

	// a held result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// the end result is empty and closes its run
	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_end |-> last_of_run && out_count == 4'd0)
		else $error("malformed end result");

	// data results carry bytes and no status
	a_data_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stream_end |-> status == ST_OK && out_count != 4'd0
			&& out_count <= 4'(CHUNK_BYTES))
		else $error("malformed data result");

	// nothing follows the end transfer
	a_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && stream_end |=> !out_valid)
		else $error("result after stream end");

endmodule

bind two_mode_lz_decompressor lzd_checker u_lzd_checker (.*);

@@ tb/sv/two_mode_lz_checker.sv @@
package lzd_tb_pkg;

	// first byte of a stream picks how the rest is parsed
	localparam logic [7:0] MODE_BITS  = 8'd0;
	localparam logic [7:0] MODE_FLAGS = 8'd1;

endpackage

module two_mode_lz_checker
	import lzd_pkg::*;
	import lzd_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] out_data,
	input  logic [3:0]  out_count,
	input  logic        last_of_run,
	input  logic        stream_end,
	input  logic [1:0]  status,
	output int          n_fail,
	output int          n_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {AWAIT_MODE, BIT_STREAM, FLAG_STREAM} stream_mode_e;
	typedef enum logic [1:0] {TK_HEAD, TK_MID, TK_TAIL} token_step_e;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  count;
		logic        last;
		logic        fin;
		logic [1:0]  st;
	} chunk_t;

	logic [7:0]   window [WINDOW_DEPTH];
	int unsigned  produced;
	stream_mode_e smode;
	token_step_e  step;
	logic [31:0]  bits;
	int unsigned  nbits;
	logic [7:0]   flags;
	int unsigned  flags_left;
	logic [7:0]   lo_b, hi_b;
	int unsigned  pend_len;
	bit           done;
	logic [63:0]  acc;
	int unsigned  acc_n;
	chunk_t       want_q [$];

	function automatic void post(logic [63:0] d, int unsigned c, bit fin, logic [1:0] st);
		chunk_t r;
		r.data  = d;
		r.count = c[3:0];
		r.last  = 1'b0;
		r.fin   = fin;
		r.st    = st;
		want_q.push_back(r);
	endfunction

	function automatic void flush_acc();
		if (acc_n > 0)
			post(acc, acc_n, 1'b0, ST_OK);
		acc   = '0;
		acc_n = 0;
	endfunction

	function automatic void finish_with(logic [1:0] st);
		flush_acc();
		post('0, 0, 1'b1, st);
		done = 1'b1;
	endfunction

	function automatic bit put_byte(logic [7:0] b);
		if (produced >= OUTPUT_LIMIT)
			return 1'b0;
		window[produced % WINDOW_DEPTH] = b;
		produced++;
		acc |= 64'(b) << (8 * acc_n);
		acc_n++;
		if (acc_n >= CHUNK_BYTES)
			flush_acc();
		return 1'b1;
	endfunction

	function automatic void put_literal(logic [7:0] b);
		if (!put_byte(b)) begin
			finish_with(ST_LIMIT);
			return;
		end
		flush_acc();
	endfunction

	// byte by byte, so an overlapping copy repeats what it has just written
	function automatic void replay(int unsigned offs, int unsigned len);
		int unsigned src;
		logic [7:0] b;
		src = produced - offs;
		for (int unsigned i = 0; i < len; i++) begin
			b = window[src % WINDOW_DEPTH];
			src++;
			if (!put_byte(b)) begin
				finish_with(ST_LIMIT);
				return;
			end
		end
		flush_acc();
	endfunction

	function automatic void take(int unsigned n);
		bits  = bits >> n;
		nbits = nbits - n;
	endfunction

	function automatic bit bit_head();
		int unsigned len;
		if (nbits < 1)
			return 1'b0;
		if (bits[0]) begin
			if (nbits < 9)
				return 1'b0;
			put_literal(bits[8:1]);
			take(9);
			return 1'b1;
		end
		len = 0;
		for (int k = 1; k <= 4 && len == 0; k++) begin
			if (nbits < k + 1)
				return 1'b0;
			if (!bits[k]) begin
				len = k + 1;
				take(k + 1);
			end
		end
		if (len == 0) begin
			if (nbits < 6)
				return 1'b0;
			if (bits[5]) begin
				take(6);
				step = TK_MID;
				return 1'b1;
			end
			if (nbits < 7)
				return 1'b0;
			len = bits[6] ? 7 : 6;
			take(7);
		end
		pend_len = len;
		step = TK_TAIL;
		return 1'b1;
	endfunction

	function automatic bit bit_count();
		int unsigned c;
		if (nbits < 2)
			return 1'b0;
		c = bits[1:0];
		if (c != 0) begin
			take(2);
			pend_len = c + 7;
			step = TK_TAIL;
			return 1'b1;
		end
		if (nbits < 9)
			return 1'b0;
		c = bits[8:2];
		take(9);
		if (c == 0) begin
			finish_with(ST_OK);
			return 1'b1;
		end
		pend_len = c + 10;
		step = TK_TAIL;
		return 1'b1;
	endfunction

	function automatic bit bit_dist();
		int unsigned offs, span, nb;
		if (nbits < 1)
			return 1'b0;
		if (bits[0]) begin
			if (nbits < 6)
				return 1'b0;
			offs = 1 + bits[5:1];
			take(6);
		end else begin
			// a far copy is refused as soon as its selector shows up if at most 33 bytes exist
			if (produced <= 33) begin
				finish_with(ST_BAD_DIST);
				return 1'b1;
			end
			span = produced - 33;
			nb = 0;
			if (span < (1 << 11)) begin
				while (span != 0) begin
					nb++;
					span = span >> 1;
				end
			end else
				nb = 12;
			if (nbits < 1 + nb)
				return 1'b0;
			offs = 33 + ((bits >> 1) & ((32'd1 << nb) - 1));
			take(1 + nb);
		end
		step = TK_HEAD;
		if (offs > produced)
			finish_with(ST_BAD_DIST);
		else
			replay(offs, pend_len);
		return 1'b1;
	endfunction

	function automatic void bit_byte(logic [7:0] b);
		bit moved;
		bits  = bits | (32'(b) << nbits);
		nbits = nbits + 8;
		while (!done) begin
			case (step)
				TK_HEAD: moved = bit_head();
				TK_MID:  moved = bit_count();
				default: moved = bit_dist();
			endcase
			if (!moved)
				break;
		end
	endfunction

	function automatic void checked_copy(int unsigned offs, int unsigned len);
		if (offs == 0 || offs > produced)
			finish_with(ST_BAD_DIST);
		else
			replay(offs, len);
	endfunction

	function automatic void flag_byte(logic [7:0] b);
		int unsigned offs;
		bit f;
		if (step == TK_HEAD) begin
			if (flags_left == 0) begin
				flags = b;
				flags_left = 8;
				return;
			end
			f = flags[7];
			flags = flags << 1;
			flags_left--;
			if (!f)
				put_literal(b);
			else begin
				lo_b = b;
				step = TK_MID;
			end
			return;
		end
		offs = 32'(lo_b[7:4]) << 8;
		if (step == TK_MID) begin
			hi_b = b;
			step = TK_HEAD;
			if (lo_b == 8'h00 && hi_b == 8'h00) begin
				finish_with(ST_OK);
				return;
			end
			offs |= hi_b;
			if (offs > produced) begin
				finish_with(ST_BAD_DIST);
				return;
			end
			if (lo_b[3:0] == 4'h0) begin
				step = TK_TAIL;
				return;
			end
			checked_copy(offs, lo_b[3:0] + 1);
			return;
		end
		step = TK_HEAD;
		offs |= hi_b;
		checked_copy(offs, 17 + b);
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		int n0;
		chunk_t r;
		acc   = '0;
		acc_n = 0;
		n0    = want_q.size();
		if (done)
			return;
		case (smode)
			AWAIT_MODE: begin
				if (b == MODE_BITS)
					smode = BIT_STREAM;
				else if (b == MODE_FLAGS)
					smode = FLAG_STREAM;
				else
					finish_with(ST_BAD_MODE);
			end
			BIT_STREAM: bit_byte(b);
			default:    flag_byte(b);
		endcase
		if (want_q.size() > n0) begin
			r = want_q.pop_back();
			r.last = 1'b1;
			want_q.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		chunk_t got, exp_r;
		if (!arst_n) begin
			produced   = 0;
			smode      = AWAIT_MODE;
			step       = TK_HEAD;
			bits       = '0;
			nbits      = 0;
			flags      = '0;
			flags_left = 0;
			lo_b       = '0;
			hi_b       = '0;
			pend_len   = 0;
			done       = 1'b0;
			acc        = '0;
			acc_n      = 0;
			want_q.delete();
			n_fail     = 0;
			n_pending  = 0;
		end else begin
			if (in_valid && !in_stall)
				predict_byte(in_byte);
			if (out_valid && !out_stall) begin
				got = {out_data, out_count, last_of_run, stream_end, status};
				if (want_q.size() == 0) begin
					$display("%0t: unexpected transfer data=%h count=%0d last=%b end=%b status=%0d",
						$time, out_data, out_count, last_of_run, stream_end, status);
					n_fail++;
				end else begin
					exp_r = want_q.pop_front();
					if (got.data !== exp_r.data || got.count !== exp_r.count ||
						got.last !== exp_r.last || got.fin !== exp_r.fin ||
						got.st !== exp_r.st) begin
						$display("%0t: expected data=%h count=%0d last=%b end=%b status=%0d",
							$time, exp_r.data, exp_r.count, exp_r.last, exp_r.fin, exp_r.st);
						$display("%0t:   actual data=%h count=%0d last=%b end=%b status=%0d",
							$time, got.data, got.count, got.last, got.fin, got.st);
						n_fail++;
					end
				end
			end
			n_pending = want_q.size();
		end
	end

endmodule

@@ tb/sv/two_mode_lz_decompressor_tb.sv @@
module two_mode_lz_decompressor_tb;
	import lzd_pkg::*;
	import lzd_tb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int TAIL_CYCLES = 64;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] out_data;
	logic [3:0]  out_count;
	logic        last_of_run;
	logic        stream_end;
	logic [1:0]  status;
	int          n_fail;
	int          n_pending;

	int unsigned cycles = 0;
	logic [7:0]  stim_q [$];
	int unsigned gen_prod;
	logic [7:0]  bacc;
	int unsigned bn;
	logic [7:0]  grp_q [$];
	logic [7:0]  grp_flags;
	int unsigned grp_n;

	two_mode_lz_decompressor u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.out_count(out_count), .last_of_run(last_of_run), .stream_end(stream_end),
		.status(status)
	);

	two_mode_lz_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.out_count(out_count), .last_of_run(last_of_run), .stream_end(stream_end),
		.status(status), .n_fail(n_fail), .n_pending(n_pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("two_mode_lz_decompressor: mismatch");
			$finish;
		end
	end

	// in every fourth window of the cycle count no new input gaps or output stalls start
	function automatic bit quiet();
		return (cycles / 700) % 4 == 3;
	endfunction

	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	always @(negedge clk) begin
		int hold;
		bit lvl;
		if (hold > 0)
			hold--;
		else begin
			lvl  = !quiet() && $urandom_range(0, 2) == 0;
			hold = lvl ? pick_gap() - 1 : $urandom_range(0, 3);
		end
		out_stall <= lvl;
	end

	// bit stream: fields go in least significant bit first
	function automatic void put_bits(logic [31:0] v, int n);
		for (int i = 0; i < n; i++) begin
			bacc[bn] = v[i];
			bn++;
			if (bn == 8) begin
				stim_q.push_back(bacc);
				bn = 0;
				bacc = '0;
			end
		end
	endfunction

	function automatic void pad_bits();
		if (bn > 0)
			put_bits($urandom, 8 - bn);
	endfunction

	function automatic int span_bits(int unsigned p);
		int unsigned span;
		int n;
		span = p - 33;
		if (span >= 2048)
			return 12;
		n = 0;
		while (span != 0) begin
			n++;
			span = span >> 1;
		end
		return n;
	endfunction

	function automatic void m0_literal(logic [7:0] b);
		put_bits(1, 1);
		put_bits(b, 8);
		gen_prod++;
	endfunction

	function automatic void m0_len(int unsigned len);
		case (len)
			2: put_bits(0, 2);
			3: put_bits(3'b010, 3);
			4: put_bits(4'b0110, 4);
			5: put_bits(5'b01110, 5);
			6: put_bits(7'b0011110, 7);
			7: put_bits(7'b1011110, 7);
			default: begin
				put_bits(6'b111110, 6);
				if (len <= 10)
					put_bits(len - 7, 2);
				else begin
					put_bits(0, 2);
					put_bits(len - 10, 7);
				end
			end
		endcase
	endfunction

	function automatic void m0_copy(int unsigned len, int unsigned offs);
		m0_len(len);
		if (offs <= 32) begin
			put_bits(1, 1);
			put_bits(offs - 1, 5);
		end else begin
			put_bits(0, 1);
			put_bits(offs - 33, span_bits(gen_prod));
		end
		gen_prod += len;
	endfunction

	function automatic void m0_random_copy();
		int unsigned len, lim;
		len = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 137) : $urandom_range(2, 10);
		if (gen_prod > 33 && $urandom_range(0, 1) == 1) begin
			lim = (gen_prod < 33 + 4095) ? gen_prod : 33 + 4095;
			m0_copy(len, ($urandom_range(0, 4) == 0) ? lim : $urandom_range(33, lim));
		end else begin
			lim = (gen_prod < 32) ? gen_prod : 32;
			m0_copy(len, $urandom_range(1, lim));
		end
	endfunction

	function automatic void m0_close();
		int nb;
		nb = span_bits(gen_prod);
		if ($urandom_range(0, 4) == 0 && 33 + (1 << nb) - 1 > gen_prod) begin
			// distance field reaches past what has been written
			m0_len($urandom_range(2, 7));
			put_bits(0, 1);
			put_bits((1 << nb) - 1, nb);
		end else begin
			put_bits(6'b111110, 6);
			put_bits(0, 9);
		end
		pad_bits();
	endfunction

	function automatic void m1_token(bit f, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
		int n);
		grp_flags[7 - grp_n] = f;
		grp_q.push_back(b0);
		if (n > 1)
			grp_q.push_back(b1);
		if (n > 2)
			grp_q.push_back(b2);
		grp_n++;
		if (grp_n == 8)
			m1_flush();
	endfunction

	function automatic void m1_flush();
		if (grp_n > 0) begin
			stim_q.push_back(grp_flags | (8'($urandom) & (8'hff >> grp_n)));
			while (grp_q.size() > 0)
				stim_q.push_back(grp_q.pop_front());
		end
		grp_n = 0;
		grp_flags = '0;
	endfunction

	function automatic void m1_literal(logic [7:0] b);
		m1_token(1'b0, b, 8'h00, 8'h00, 1);
		gen_prod++;
	endfunction

	function automatic void m1_pair(int unsigned len, int unsigned offs);
		logic [11:0] d;
		d = offs[11:0];
		if (len <= 16)
			m1_token(1'b1, {d[11:8], 4'(len - 1)}, d[7:0], 8'h00, 2);
		else
			m1_token(1'b1, {d[11:8], 4'h0}, d[7:0], 8'(len - 17), 3);
	endfunction

	function automatic void m1_copy(int unsigned len, int unsigned offs);
		m1_pair(len, offs);
		gen_prod += len;
	endfunction

	function automatic void m1_random_copy();
		int unsigned len, lim;
		len = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 16) : $urandom_range(17, 272);
		lim = (gen_prod < 4095) ? gen_prod : 4095;
		m1_copy(len, ($urandom_range(0, 4) == 0) ? lim : $urandom_range(1, lim));
	endfunction

	function automatic void m1_close();
		if ($urandom_range(0, 4) == 0) begin
			if (gen_prod < 4095 && $urandom_range(0, 1) == 1)
				m1_pair($urandom_range(2, 16), gen_prod + 1);
			else
				m1_pair($urandom_range(2, 16), 0);
		end else
			m1_token(1'b1, 8'h00, 8'h00, 8'h00, 2);
		m1_flush();
	endfunction

	function automatic void build_stimulus();
		int v;
		gen_prod = 0;
		bacc = '0;
		bn = 0;
		grp_flags = '0;
		grp_n = 0;
		v = $urandom_range(0, 19);
		if (v == 0)
			stim_q.push_back(8'($urandom_range(2, 255)));
		else if (v < 10) begin
			stim_q.push_back(MODE_BITS);
			if (v == 1) begin
				// far copy before enough output exists
				m0_literal($urandom);
				m0_len(3);
				put_bits(0, 1);
				pad_bits();
			end else begin
				m0_literal(8'h00);
				m0_literal(8'hff);
				m0_copy(2, 2);
				m0_copy(3, 1);
				m0_copy(137, 2);
				for (int len = 4; len <= 11; len++)
					m0_copy(len, $urandom_range(1, 32));
				m0_copy(8, gen_prod);
				m0_copy(9, 33);
				m0_copy(10, 32);
				while (stim_q.size() < 300) begin
					if ($urandom_range(0, 2) == 0)
						m0_literal($urandom);
					else
						m0_random_copy();
				end
				m0_close();
			end
		end else begin
			stim_q.push_back(MODE_FLAGS);
			if (v == 19) begin
				// long copies until the output limit trips
				m1_literal($urandom);
				repeat (140)
					m1_copy(272, 1);
				m1_flush();
			end else begin
				m1_literal(8'h00);
				m1_literal(8'hff);
				m1_copy(2, 1);
				m1_copy(16, gen_prod);
				m1_copy(17, 1);
				m1_copy(272, 3);
				m1_copy(5, gen_prod);
				while (stim_q.size() < 300) begin
					if ($urandom_range(0, 9) < 4)
						m1_literal($urandom);
					else
						m1_random_copy();
				end
				m1_close();
			end
		end
		// stream is over: these are dropped by the block
		repeat (6)
			stim_q.push_back($urandom);
		while (stim_q.size() < 310)
			stim_q.push_back($urandom);
	endfunction

	initial begin
		int g;
		in_valid = 1'b0;
		in_byte  = '0;
		arst_n   = 1'b0;
		build_stimulus();
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (stim_q[i]) begin
			g = (quiet() || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
			if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(negedge clk);
			end
			in_valid <= 1'b1;
			in_byte  <= stim_q[i];
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			@(negedge clk);
		end
		in_valid <= 1'b0;
		while (n_pending != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (n_fail == 0 && n_pending == 0)
			$display("two_mode_lz_decompressor: match");
		else
			$display("two_mode_lz_decompressor: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
rtl/lzd_pkg.sv
rtl/lzd_hist_ram.sv
rtl/two_mode_lz_decompressor.sv
rtl/lzd_checker.sv
tb/sv/two_mode_lz_checker.sv
tb/sv/two_mode_lz_decompressor_tb.sv
